// File: design/dett_pkg.sv
// Package of the decayed evidence trust table: widths, fixed-point constants,
// operation and register codes. Depends on nothing; used by every design file.
package dett_pkg;

	localparam int NUM_SENSORS = 16;
	localparam int FRAC_BITS = 16;

	localparam int SENSOR_W = 4;
	localparam int MODE_W = 2;
	localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	localparam int COUNT_W = 24;
	localparam int FACT_W = 17;
	localparam int FACT_FRAC = 16;
	localparam int TRUST_W = 17;
	localparam int QUOT_W = 16;
	localparam int DEN_W = COUNT_W + 2;
	localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

	localparam logic [FACT_W-1:0] Q16_ONE = FACT_W'(1) << FACT_FRAC;
	localparam logic [DEN_W-1:0] COUNT_ONE = DEN_W'(1) << FRAC_BITS;
	localparam logic [DEN_W-1:0] COUNT_MAX = DEN_W'({COUNT_W{1'b1}});

	localparam logic [FACT_W-1:0] GOOD_FORGET_RST = FACT_W'(62259);
	localparam logic [FACT_W-1:0] BAD_FORGET_RST = FACT_W'(62259);
	localparam logic [TRUST_W-1:0] DEFAULT_TRUST_RST = TRUST_W'(32768);

	typedef enum logic [MODE_W-1:0] {
		MODE_UPDATE = 2'd0,
		MODE_DECAY  = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_QUERY2 = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_GOOD_FORGET   = 2'd0,
		REG_BAD_FORGET    = 2'd1,
		REG_DEFAULT_TRUST = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MULG   = 7'b0000010,
		ST_MULB   = 7'b0000100,
		ST_ADD    = 7'b0001000,
		ST_DIVSET = 7'b0010000,
		ST_DIV    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

endpackage

// File: design/dett_divider.sv
// Bit-serial restoring divider of the trust table: one quotient bit a cycle.
// Depends on dett_pkg for its widths.
module dett_divider
	import dett_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEN_W-1:0]  numer,
	input  logic [DEN_W-1:0]  denom,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [QUOT_W-1:0]    quot_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	// The remainder stays below the divisor, so one doubled remainder needs one extra bit.
	assign shifted = {rem_q, 1'b0};
	assign diff = shifted - {1'b0, den_q};
	assign fits = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
			den_q <= denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: design/decayed_evidence_trust_table.sv
// Top level of the decayed evidence trust table: sequencer, count storage,
// shared multiplier and output register. Depends on dett_pkg and dett_divider.
//
// Each transaction on the slave stream carries one operation: s_tuser holds the
// mode (update, decay or query) and s_tdata the sensor index and, for an update,
// the outcome of the check. Every operation yields exactly one transaction on the
// master stream with the sensor's trust in Q1.16 and, in m_tuser, a flag that is
// set when the sensor has counts of its own. Forgetting factors and the default
// trust are to be written through the plain write port only while the block is
// idle; the block itself does not enforce this.
//
// An update or decay runs two multiplier passes, one add, a divider load, the
// divider, which yields the quotient one bit at a time, the quotient capture and
// the output load. A query of a known sensor skips the multiplier and the add, and
// a query of an unknown sensor goes straight to the output load. s_tready is high
// only while the sequencer is idle, so the block takes no new operation until the
// last one's result is in the output register. Reset restores the register
// defaults and marks every sensor unseen. When the receiver stalls, the result
// waits in the output register; the block still accepts the next operation and
// holds its result until the output register is free.
module decayed_evidence_trust_table
	import dett_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [FACT_W-1:0]  cfg_wdata,
	// Operation stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [3:0] sensor, [4] is_good, [7:5] zero
	input  logic [MODE_W-1:0]  s_tuser,  // [1:0] mode
	// Result stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,  // [16:0] trust, [23:17] zero
	output logic               m_tuser   // [0] known
);

	function automatic logic [FACT_W-1:0] clamp_one(input logic [FACT_W-1:0] v);
		return (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

	// Configuration registers.
	logic [FACT_W-1:0]  good_forget_q;
	logic [FACT_W-1:0]  bad_forget_q;
	logic [TRUST_W-1:0] default_trust_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_forget_q <= GOOD_FORGET_RST;
			bad_forget_q <= BAD_FORGET_RST;
			default_trust_q <= DEFAULT_TRUST_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GOOD_FORGET:   good_forget_q <= cfg_wdata;
				REG_BAD_FORGET:    bad_forget_q <= cfg_wdata;
				REG_DEFAULT_TRUST: default_trust_q <= TRUST_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Sensor storage. Counts are only read for seen sensors, so they need no reset.
	logic [NUM_SENSORS-1:0] seen_q;
	logic [COUNT_W-1:0]     good_mem [NUM_SENSORS];
	logic [COUNT_W-1:0]     bad_mem [NUM_SENSORS];

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	mode_t              mode_q;
	logic               is_good_q;
	logic [COUNT_W-1:0] g_q;
	logic [COUNT_W-1:0] b_q;
	logic [TRUST_W-1:0] res_trust_q;
	logic               res_known_q;
	logic               m_tvalid_q;
	logic [TRUST_W-1:0] m_trust_q;
	logic               m_known_q;

	logic             accept;
	logic [SENSOR_W-1:0] in_sensor;
	logic             in_good;
	mode_t            in_mode;
	logic [IDX_W-1:0] in_idx;
	logic             in_range;
	logic             in_seen;
	logic             in_touch;
	logic             cur_touch;
	logic             out_load;

	assign in_sensor = s_tdata[SENSOR_W-1:0];
	assign in_good = s_tdata[SENSOR_W];
	assign in_mode = mode_t'(s_tuser);
	assign in_idx = IDX_W'(in_sensor);
	assign in_range = (32'(in_sensor) < NUM_SENSORS);
	assign in_seen = seen_q[in_idx];
	assign in_touch = (in_mode == MODE_UPDATE) || (in_mode == MODE_DECAY);
	assign cur_touch = (mode_q == MODE_UPDATE) || (mode_q == MODE_DECAY);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// The output register takes a new result when it is empty or being emptied.
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// One multiplier serves both counts, the good one first, then the bad one.
	logic [COUNT_W-1:0]        mul_count;
	logic [FACT_W-1:0]         mul_factor;
	logic [COUNT_W+FACT_W-1:0] mul_prod;
	logic [COUNT_W-1:0]        mul_scaled;

	assign mul_count = (state_q == ST_MULG) ? g_q : b_q;
	assign mul_factor = (state_q == ST_MULG) ? clamp_one(good_forget_q) : clamp_one(bad_forget_q);
	assign mul_prod = (COUNT_W+FACT_W)'(mul_count) * (COUNT_W+FACT_W)'(mul_factor);
	// A factor of at most one never grows the count, so the slice cannot overflow.
	assign mul_scaled = mul_prod[COUNT_W+FACT_FRAC-1:FACT_FRAC];

	// Saturating addition of one unit of evidence to the selected count.
	logic [COUNT_W-1:0] add_src;
	logic [DEN_W-1:0]   add_sum;
	logic [COUNT_W-1:0] add_sat;

	assign add_src = is_good_q ? g_q : b_q;
	assign add_sum = DEN_W'(add_src) + COUNT_ONE;
	assign add_sat = (add_sum > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : add_sum[COUNT_W-1:0];

	// Trust ratio (g + 1) / (g + b + 2) in Q0.16.
	logic [DEN_W-1:0]  div_numer;
	logic [DEN_W-1:0]  div_denom;
	logic              div_start;
	logic              div_done;
	logic [QUOT_W-1:0] div_quot;

	assign div_numer = DEN_W'(g_q) + COUNT_ONE;
	assign div_denom = DEN_W'(g_q) + DEN_W'(b_q) + (COUNT_ONE << 1);
	assign div_start = (state_q == ST_DIVSET);

	dett_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!in_range) begin
							state_q <= ST_OUT;
						end else if (in_touch) begin
							state_q <= ST_MULG;
						end else if (in_seen) begin
							state_q <= ST_DIVSET;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MULG: state_q <= ST_MULB;
				ST_MULB: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_DIVSET;
				ST_DIVSET: begin
					if (cur_touch) begin
						seen_q[idx_q] <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers, storage writes and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q <= in_idx;
					mode_q <= in_mode;
					is_good_q <= in_good;
					// A first touch starts both counts at zero.
					g_q <= (in_range && in_seen) ? good_mem[in_idx] : '0;
					b_q <= (in_range && in_seen) ? bad_mem[in_idx] : '0;
					res_trust_q <= clamp_one(default_trust_q);
					res_known_q <= 1'b0;
				end
			end
			ST_MULG: g_q <= mul_scaled;
			ST_MULB: b_q <= mul_scaled;
			ST_ADD: begin
				if (mode_q == MODE_UPDATE) begin
					if (is_good_q) begin
						g_q <= add_sat;
					end else begin
						b_q <= add_sat;
					end
				end
			end
			ST_DIVSET: begin
				if (cur_touch) begin
					good_mem[idx_q] <= g_q;
					bad_mem[idx_q] <= b_q;
				end
				res_known_q <= 1'b1;
			end
			ST_DIV: begin
				if (div_done) begin
					res_trust_q <= TRUST_W'(div_quot);
				end
			end
			ST_OUT: begin
				if (out_load) begin
					m_trust_q <= res_trust_q;
					m_known_q <= res_known_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {(24 - TRUST_W)'(0), m_trust_q};
	assign m_tuser = m_known_q;

endmodule
